@@ hw/rtl/qpr_pkg.sv @@
// Package: default widths and status codes for the quaternion point rotator.
package qpr_pkg;

    localparam int QUAT_WIDTH_DEF  = 16;
    localparam int POINT_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_ZERO = 2'd1,
        STATUS_SAT  = 2'd2
    } status_t;

endpackage

@@ hw/rtl/quaternion_point_rotator.sv @@
// Top level: pipelined quaternion point rotation with a bit-per-stage divider.
// Throughput: one transaction per cycle unless the output stalls; each stage holds
// one item, and a stalled output stage backs up only the stages behind it, so bubbles
// are squeezed out.
// The divider is one restoring step per stage, POINT_WIDTH stages deep.
// Reset clears all valid bits; payload registers are not reset.
module quaternion_point_rotator
    import qpr_pkg::*;
#(
    parameter int QUAT_WIDTH  = QUAT_WIDTH_DEF,
    parameter int POINT_WIDTH = POINT_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [QUAT_WIDTH-1:0]  quat_w,
    input  logic signed [QUAT_WIDTH-1:0]  quat_x,
    input  logic signed [QUAT_WIDTH-1:0]  quat_y,
    input  logic signed [QUAT_WIDTH-1:0]  quat_z,
    input  logic signed [POINT_WIDTH-1:0] point_x,
    input  logic signed [POINT_WIDTH-1:0] point_y,
    input  logic signed [POINT_WIDTH-1:0] point_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [POINT_WIDTH-1:0] rot_x,
    output logic signed [POINT_WIDTH-1:0] rot_y,
    output logic signed [POINT_WIDTH-1:0] rot_z,
    output logic [1:0]                    status
);

    localparam int QW  = QUAT_WIDTH;
    localparam int PW  = POINT_WIDTH;
    localparam int QP  = QW + PW;          // q * p product
    localparam int SQ  = 2 * QW;           // q * q product
    localparam int NNW = 2 * QW + 2;       // norm, s
    localparam int DW  = QW + PW + 3;      // 2 * (u . p)
    localparam int CW  = QW + PW + 1;      // cross product term
    localparam int WW  = QW + 1;           // 2 * w
    localparam int NW  = 2 * QW + PW + 5;  // numerator
    localparam int DIV = 3;                // pipeline index of first divider entry
    localparam int L   = PW + 5;           // stage count

    logic [L-1:0] v_reg;
    logic [L-1:0] en;

    always_comb
    begin
        en[L-1] = !v_reg[L-1] || out_ready;
        for (int i = L - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[L-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < L; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // stage 0: first products
    logic signed [SQ-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [QP-1:0] xpx_reg, ypy_reg, zpz_reg;
    logic signed [QP-1:0] ypz_reg, zpy_reg, zpx_reg, xpz_reg, xpy_reg, ypx_reg;
    logic signed [QW-1:0] w0_reg, x0_reg, y0_reg, z0_reg;
    logic signed [PW-1:0] px0_reg, py0_reg, pz0_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ww_reg  <= quat_w * quat_w;
            xx_reg  <= quat_x * quat_x;
            yy_reg  <= quat_y * quat_y;
            zz_reg  <= quat_z * quat_z;
            xpx_reg <= quat_x * point_x;
            ypy_reg <= quat_y * point_y;
            zpz_reg <= quat_z * point_z;
            ypz_reg <= quat_y * point_z;
            zpy_reg <= quat_z * point_y;
            zpx_reg <= quat_z * point_x;
            xpz_reg <= quat_x * point_z;
            xpy_reg <= quat_x * point_y;
            ypx_reg <= quat_y * point_x;
            w0_reg  <= quat_w;
            x0_reg  <= quat_x;
            y0_reg  <= quat_y;
            z0_reg  <= quat_z;
            px0_reg <= point_x;
            py0_reg <= point_y;
            pz0_reg <= point_z;
        end
    end

    // stage 1: sums
    logic signed [NNW-1:0] ww_e, xx_e, yy_e, zz_e, uu_e;
    logic signed [DW-1:0]  xpx_e, ypy_e, zpz_e, dot_e;
    logic signed [CW-1:0]  cx_a, cx_b, cy_a, cy_b, cz_a, cz_b;
    logic signed [WW-1:0]  w_e;

    assign ww_e  = NNW'(ww_reg);
    assign xx_e  = NNW'(xx_reg);
    assign yy_e  = NNW'(yy_reg);
    assign zz_e  = NNW'(zz_reg);
    assign uu_e  = xx_e + yy_e + zz_e;
    assign xpx_e = DW'(xpx_reg);
    assign ypy_e = DW'(ypy_reg);
    assign zpz_e = DW'(zpz_reg);
    assign dot_e = xpx_e + ypy_e + zpz_e;
    assign cx_a  = CW'(ypz_reg);
    assign cx_b  = CW'(zpy_reg);
    assign cy_a  = CW'(zpx_reg);
    assign cy_b  = CW'(xpz_reg);
    assign cz_a  = CW'(xpy_reg);
    assign cz_b  = CW'(ypx_reg);
    assign w_e   = WW'(w0_reg);

    logic [NNW-1:0]        n1_reg;
    logic signed [NNW-1:0] s1_reg;
    logic signed [DW-1:0]  d21_reg;
    logic signed [CW-1:0]  cx1_reg, cy1_reg, cz1_reg;
    logic signed [WW-1:0]  w21_reg;
    logic signed [QW-1:0]  x1_reg, y1_reg, z1_reg;
    logic signed [PW-1:0]  px1_reg, py1_reg, pz1_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            n1_reg  <= ww_e + uu_e;
            s1_reg  <= ww_e - uu_e;
            d21_reg <= dot_e <<< 1;
            cx1_reg <= cx_a - cx_b;
            cy1_reg <= cy_a - cy_b;
            cz1_reg <= cz_a - cz_b;
            w21_reg <= w_e <<< 1;
            x1_reg  <= x0_reg;
            y1_reg  <= y0_reg;
            z1_reg  <= z0_reg;
            px1_reg <= px0_reg;
            py1_reg <= py0_reg;
            pz1_reg <= pz0_reg;
        end
    end

    // stage 2: second products
    logic signed [NW-1:0] sp_reg [3];
    logic signed [NW-1:0] du_reg [3];
    logic signed [NW-1:0] wc_reg [3];
    logic [NNW-1:0]       n2_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            sp_reg[0] <= s1_reg * px1_reg;
            sp_reg[1] <= s1_reg * py1_reg;
            sp_reg[2] <= s1_reg * pz1_reg;
            du_reg[0] <= d21_reg * x1_reg;
            du_reg[1] <= d21_reg * y1_reg;
            du_reg[2] <= d21_reg * z1_reg;
            wc_reg[0] <= w21_reg * cx1_reg;
            wc_reg[1] <= w21_reg * cy1_reg;
            wc_reg[2] <= w21_reg * cz1_reg;
            n2_reg    <= n1_reg;
        end
    end

    // stage 3: numerator, sign/magnitude, overflow check, divider setup
    logic signed [NW-1:0] num [3];
    logic [NW-1:0]        mag [3];
    logic [NW-1:0]        nshift;
    logic                 ovf [3];

    assign nshift = {{(NW - NNW - PW){1'b0}}, n2_reg, {PW{1'b0}}};

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            num[j] = sp_reg[j] + du_reg[j] + wc_reg[j];
            mag[j] = num[j][NW-1] ? NW'(-num[j]) : NW'(num[j]);
            ovf[j] = mag[j] >= nshift;
        end
    end

    logic [NNW-1:0] rem_reg  [PW+1][3];
    logic [PW-1:0]  low_reg  [PW+1][3];
    logic [PW-1:0]  quo_reg  [PW+1][3];
    logic           neg_reg  [PW+1][3];
    logic           ovf_reg  [PW+1][3];
    logic [NNW-1:0] dn_reg   [PW+1];

    always_ff @(posedge clk)
    begin
        if (en[DIV])
        begin
            for (int j = 0; j < 3; j++)
            begin
                rem_reg[0][j] <= mag[j][PW +: NNW];
                low_reg[0][j] <= mag[j][PW-1:0];
                quo_reg[0][j] <= '0;
                neg_reg[0][j] <= num[j][NW-1];
                ovf_reg[0][j] <= ovf[j];
            end
            dn_reg[0] <= n2_reg;
        end
    end

    // divider: one restoring step per stage
    for (genvar k = 1; k <= PW; k++)
    begin : g_div
        logic [NNW:0] t [3];
        logic         ge [3];

        always_comb
        begin
            for (int j = 0; j < 3; j++)
            begin
                t[j]  = {rem_reg[k-1][j], low_reg[k-1][j][PW-1]};
                ge[j] = t[j] >= {1'b0, dn_reg[k-1]};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[DIV+k])
            begin
                for (int j = 0; j < 3; j++)
                begin
                    rem_reg[k][j] <= ge[j] ? NNW'(t[j] - {1'b0, dn_reg[k-1]})
                                           : NNW'(t[j]);
                    low_reg[k][j] <= low_reg[k-1][j] << 1;
                    quo_reg[k][j] <= {quo_reg[k-1][j][PW-2:0], ge[j]};
                    neg_reg[k][j] <= neg_reg[k-1][j];
                    ovf_reg[k][j] <= ovf_reg[k-1][j];
                end
                dn_reg[k] <= dn_reg[k-1];
            end
        end
    end

    // output stage: round half away from zero, saturate
    localparam logic [PW:0] POS_MAX = {2'b00, {(PW-1){1'b1}}};
    localparam logic [PW:0] NEG_MAX = {2'b01, {(PW-1){1'b0}}};

    logic [PW:0]   qr   [3];
    logic [PW-1:0] res  [3];
    logic          sat  [3];
    logic          zero_n;

    assign zero_n = (dn_reg[PW] == '0);

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            qr[j] = {1'b0, quo_reg[PW][j]}
                  + (PW+1)'({rem_reg[PW][j], 1'b0} >= {1'b0, dn_reg[PW]});
            if (!neg_reg[PW][j])
            begin
                sat[j] = ovf_reg[PW][j] || (qr[j] > POS_MAX);
                res[j] = sat[j] ? POS_MAX[PW-1:0] : qr[j][PW-1:0];
            end
            else
            begin
                sat[j] = ovf_reg[PW][j] || (qr[j] > NEG_MAX);
                res[j] = sat[j] ? NEG_MAX[PW-1:0] : PW'(-qr[j]);
            end
        end
    end

    logic signed [PW-1:0] rx_reg, ry_reg, rz_reg;
    logic [1:0]           st_reg;

    always_ff @(posedge clk)
    begin
        if (en[L-1])
        begin
            if (zero_n)
            begin
                rx_reg <= '0;
                ry_reg <= '0;
                rz_reg <= '0;
                st_reg <= STATUS_ZERO;
            end
            else
            begin
                rx_reg <= res[0];
                ry_reg <= res[1];
                rz_reg <= res[2];
                st_reg <= (sat[0] || sat[1] || sat[2]) ? STATUS_SAT : STATUS_OK;
            end
        end
    end

    assign rot_x  = rx_reg;
    assign rot_y  = ry_reg;
    assign rot_z  = rz_reg;
    assign status = st_reg;

endmodule
